### design/chih_pkg.sv
// shared constants, types and functions of the color histogram hash core
package chih_pkg;
    localparam int COUNT_BITS = 24;
    localparam int HUE_BINS   = 6;
    localparam int NUM_VALS   = 2 + 2 * HUE_BINS;
    localparam int HASH_BITS  = 3 * NUM_VALS;
    localparam int CFG_IDX_BITS = 2;
    localparam int QDEPTH = 4;

    localparam logic [CFG_IDX_BITS-1:0] REG_BLACK  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRAY   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        CLS_BLACK   = 2'd0,
        CLS_GRAY    = 2'd1,
        CLS_FAINT   = 2'd2,
        CLS_BRIGHT  = 2'd3
    } t_cls;

    // one classified pixel as it travels from front to back
    typedef struct packed {
        t_cls       cls;
        logic       binned;
        logic [2:0] bin;
        logic       last;
    } t_req;

    function automatic logic [2:0] alias3(input logic [2:0] v);
        logic [2:0] t;
        case (v)
            3'd0: t = 3'd0;
            3'd1: t = 3'd1;
            3'd2: t = 3'd2;
            3'd3: t = 3'd3;
            3'd4: t = 3'd6;
            3'd5: t = 3'd7;
            3'd6: t = 3'd6;
            default: t = 3'd7;
        endcase
        return {t[0], t[1], t[2]};
    endfunction
endpackage

### design/chih_divider.sv
// restoring divider: q = a / b over 19 bit-steps, a up to 19 bits, b up to 11
module chih_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [18:0] i_num,
    input  logic [10:0] i_den,
    output logic        o_done,
    output logic [18:0] o_quo
);
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [18:0] r_num;
    logic [10:0] r_den;
    logic [11:0] r_rem;
    logic [11:0] w_sh;

    assign w_sh = {r_rem[10:0], r_num[18]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd19;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_num <= {r_num[17:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_num <= {r_num[17:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_num;
endmodule

### design/chih_front.sv
// front: pixel classification into black, gray or hue bins
module chih_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    input  logic                 i_last_pixel,
    input  logic [7:0]           i_black_level,
    input  logic [7:0]           i_gray_sat_level,
    input  logic [7:0]           i_bright_sat_level,
    output logic                 o_valid,
    input  logic                 i_full,
    output chih_pkg::t_req       o_req
);
    import chih_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SAT, S_HUE, S_PUSH} t_state;

    t_state      r_state;
    logic [7:0]  r_r, r_g, r_b, r_mx, r_d;
    logic        r_last, r_black;
    logic [7:0]  r_sat;
    logic        r_start;
    logic [18:0] r_num;
    logic [10:0] r_den;
    logic        w_done;
    logic [18:0] w_quo;
    logic [7:0]  w_mx, w_mn, w_d;
    logic [10:0] w_n;
    logic [24:0] w_luma;
    logic [2:0]  w_bin;
    t_req        r_req;

    assign w_mx = (i_red > i_green) ? ((i_red > i_blue) ? i_red : i_blue)
                                    : ((i_green > i_blue) ? i_green : i_blue);
    assign w_mn = (i_red < i_green) ? ((i_red < i_blue) ? i_red : i_blue)
                                    : ((i_green < i_blue) ? i_green : i_blue);
    assign w_d  = w_mx - w_mn;
    assign w_luma = 25'(i_red) * 25'd19595 + 25'(i_green) * 25'd38470
                  + 25'(i_blue) * 25'd7471 + 25'h8000;

    always_comb begin
        if (r_r == r_mx) begin
            w_n = (r_g >= r_b) ? 11'(r_g - r_b)
                               : 11'(11'd6 * 11'(r_d) + 11'(r_g) - 11'(r_b));
        end else if (r_g == r_mx) begin
            w_n = 11'(11'd2 * 11'(r_d) + 11'(r_b) - 11'(r_r));
        end else begin
            w_n = 11'(11'd4 * 11'(r_d) + 11'(r_r) - 11'(r_g));
        end
    end

    // hue bin from hue: floor(2 hue / 85) capped at 5
    always_comb begin
        logic [7:0] h;
        h = w_quo[7:0];
        if (r_d == 8'd0)      w_bin = 3'd0;
        else if (h >= 8'd213) w_bin = 3'd5;
        else if (h >= 8'd170) w_bin = 3'd4;
        else if (h >= 8'd128) w_bin = 3'd3;
        else if (h >= 8'd85)  w_bin = 3'd2;
        else if (h >= 8'd43)  w_bin = 3'd1;
        else                  w_bin = 3'd0;
    end

    chih_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_num(r_num), .i_den(r_den), .o_done(w_done), .o_quo(w_quo)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_PUSH);
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_r <= i_red; r_g <= i_green; r_b <= i_blue;
                        r_mx <= w_mx; r_d <= w_d; r_last <= i_last_pixel;
                        r_black <= (w_luma[23:16] < i_black_level);
                        r_num <= 19'(19'd255 * 19'(w_d));
                        r_den <= (w_mx == 8'd0) ? 11'd1 : 11'(w_mx);
                        r_start <= 1'b1;
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (w_done) begin
                        r_sat <= (r_d == 8'd0) ? 8'd0 : w_quo[7:0];
                        r_num <= 19'(19'd255 * 19'(w_n));
                        r_den <= (r_d == 8'd0) ? 11'd1 : 11'(11'd6 * 11'(r_d));
                        r_start <= 1'b1;
                        r_state <= S_HUE;
                    end
                end
                S_HUE: begin
                    if (w_done) begin
                        r_req.last <= r_last;
                        r_req.bin  <= w_bin;
                        r_req.binned <= 1'b1;
                        if (r_black) begin
                            r_req.cls <= CLS_BLACK;
                        end else if (r_sat < i_gray_sat_level) begin
                            r_req.cls <= CLS_GRAY;
                        end else if (r_sat < i_bright_sat_level) begin
                            r_req.cls <= CLS_FAINT;
                        end else begin
                            r_req.cls <= CLS_BRIGHT;
                            r_req.binned <= (r_sat != i_bright_sat_level);
                        end
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### design/chih_queue.sv
// small request queue between front and back
module chih_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  chih_pkg::t_req  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output chih_pkg::t_req  o_data
);
    import chih_pkg::*;
    localparam int AW = $clog2(QDEPTH);

    t_req        r_mem [QDEPTH];
    logic [AW:0] r_wp, r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[AW-1:0] == r_rp[AW-1:0]) && (r_wp[AW] != r_rp[AW]);
    assign o_data  = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_mem[r_wp[AW-1:0]] <= i_data;
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
        end
    end
endmodule

### design/chih_back.sv
// back: saturating counters and hash formation
module chih_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  chih_pkg::t_req              i_req,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [chih_pkg::HASH_BITS-1:0] o_hash_value
);
    import chih_pkg::*;

    typedef enum logic [1:0] {S_RUN, S_QUANT, S_OUT} t_state;

    t_state                r_state;
    logic [COUNT_BITS-1:0] r_pix, r_blk, r_gry, r_col;
    logic [COUNT_BITS-1:0] r_faint [HUE_BINS];
    logic [COUNT_BITS-1:0] r_bright [HUE_BINS];
    logic [3:0]            r_idx;
    logic [HASH_BITS-1:0]  r_hash;
    logic [COUNT_BITS-1:0] w_cnt, w_tot;
    logic [COUNT_BITS+3:0] w_c8, w_t8;
    logic [2:0]            w_q;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    always_comb begin
        w_tot = (r_idx < 4'd2) ? r_pix : ((r_col == '0) ? COUNT_BITS'(1) : r_col);
        if (r_idx == 4'd0)      w_cnt = r_blk;
        else if (r_idx == 4'd1) w_cnt = r_gry;
        else if (r_idx < 4'd8)  w_cnt = r_faint[3'(r_idx - 4'd2)];
        else                    w_cnt = r_bright[3'(r_idx - 4'd8)];
    end

    // floor(8c/t) capped at 7, one compare per bit
    always_comb begin
        logic [COUNT_BITS+3:0] rem;
        w_c8 = {w_cnt, 4'b0} >> 1;
        w_t8 = {4'b0, w_tot};
        rem = w_c8;
        w_q = 3'd0;
        if (rem >= (w_t8 << 3)) begin
            w_q = 3'd7;
        end else begin
            if (rem >= (w_t8 << 2)) begin w_q[2] = 1'b1; rem = rem - (w_t8 << 2); end
            if (rem >= (w_t8 << 1)) begin w_q[1] = 1'b1; rem = rem - (w_t8 << 1); end
            if (rem >= w_t8)        begin w_q[0] = 1'b1; end
        end
    end

    assign o_pop        = (r_state == S_RUN) && !i_empty;
    assign o_valid      = (r_state == S_OUT);
    assign o_hash_value = r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_pix <= '0; r_blk <= '0; r_gry <= '0; r_col <= '0;
            r_idx <= '0;
            for (int i = 0; i < HUE_BINS; i++) begin
                r_faint[i]  <= '0;
                r_bright[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_RUN: begin
                    if (!i_empty) begin
                        r_pix <= sat_inc(r_pix);
                        case (i_req.cls)
                            CLS_BLACK: r_blk <= sat_inc(r_blk);
                            CLS_GRAY:  r_gry <= sat_inc(r_gry);
                            CLS_FAINT: begin
                                r_col <= sat_inc(r_col);
                                r_faint[i_req.bin] <= sat_inc(r_faint[i_req.bin]);
                            end
                            default: begin
                                r_col <= sat_inc(r_col);
                                if (i_req.binned)
                                    r_bright[i_req.bin] <= sat_inc(r_bright[i_req.bin]);
                            end
                        endcase
                        if (i_req.last) begin
                            r_idx <= '0;
                            r_state <= S_QUANT;
                        end
                    end
                end
                S_QUANT: begin
                    r_hash[3*r_idx +: 3] <= alias3(w_q);
                    if (r_idx == 4'(NUM_VALS - 1)) begin
                        r_state <= S_OUT;
                    end
                    r_idx <= r_idx + 4'd1;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_pix <= '0; r_blk <= '0; r_gry <= '0; r_col <= '0;
                        for (int i = 0; i < HUE_BINS; i++) begin
                            r_faint[i]  <= '0;
                            r_bright[i] <= '0;
                        end
                        r_state <= S_RUN;
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end
endmodule

### design/color_histogram_image_hash_core.sv
// top level of the color histogram image hash core
//  channel  | direction | handshake           | payload
//  pixel    | in        | i_valid / o_stall   | i_red i_green i_blue i_last_pixel
//  hash     | out       | o_valid / i_stall   | o_hash_value
//  config   | in        | i_cfg_we            | i_cfg_index i_cfg_data
// a pixel passes two 19-step divisions in the front (saturation, hue)
// the back counts a request per cycle in S_RUN; the last pixel starts quantization
// reset clears counters and loads the default levels
// an unaccepted hash holds the back; the queue lets the front go on meanwhile
module color_histogram_image_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_last_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [chih_pkg::HASH_BITS-1:0] o_hash_value,
    input  logic        i_cfg_we,
    input  logic [chih_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import chih_pkg::*;

    logic [7:0] r_black, r_gray, r_bright;
    logic       w_fv, w_full, w_empty, w_pop;
    t_req       w_freq, w_qreq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black  <= 8'd32;
            r_gray   <= 8'd85;
            r_bright <= 8'd170;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BLACK:  r_black  <= i_cfg_data;
                REG_GRAY:   r_gray   <= i_cfg_data;
                REG_BRIGHT: r_bright <= i_cfg_data;
                default: ;
            endcase
        end
    end

    chih_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .i_last_pixel(i_last_pixel), .i_black_level(r_black),
        .i_gray_sat_level(r_gray), .i_bright_sat_level(r_bright),
        .o_valid(w_fv), .i_full(w_full), .o_req(w_freq)
    );

    chih_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_fv), .i_data(w_freq),
        .o_full(w_full), .i_pop(w_pop), .o_empty(w_empty), .o_data(w_qreq)
    );

    chih_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_req(w_qreq),
        .o_pop(w_pop), .o_valid(o_valid), .i_stall(i_stall),
        .o_hash_value(o_hash_value)
    );
endmodule
